/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("check failed");
`endif

/* rtl/ntc_pkg.sv */
// Shared types and constants for the thermistor temperature block.
`timescale 1ns / 1ps
package ntc_pkg;
  localparam int AdcBits   = 12;
  localparam int FracBits  = 24;
  localparam int MantBits  = 30;
  localparam int FaultLimit = 3;
  localparam logic [2:0] RunMax = 3'd7;
  localparam logic [29:0] Ln2Q30 = 30'd744261118;
  // 100 * B * 2^24 and B * T0 * 10000 * 2^24 for the beta equation.
  localparam logic signed [47:0] DenBase = 48'sd6627000320000;
  localparam logic [57:0] NumConst = 58'd197584014540800000;
  localparam logic signed [16:0] TempLo = -17'sd27315;
  localparam logic signed [16:0] TempHi = 17'sd60000;
  localparam logic signed [16:0] Sentinel = -17'sd10000;
  localparam logic [1:0] StNormal = 2'd0;
  localparam logic [1:0] StFault  = 2'd1;
  localparam logic [1:0] StTest   = 2'd2;
  localparam logic [0:0] RegFaultLow  = 1'd0;
  localparam logic [0:0] RegFaultHigh = 1'd1;

  typedef struct packed {
    logic load;      // latch the sample and feed it to the log of the first operand
    logic log_start; // start a log
    logic log_sel;   // 0: adc, 1: 4096 - adc
    logic log_save;  // keep the first log result
    logic mul_start; // scale the log difference by ln 2 and form the denominator
    logic div_start;
  } ntc_cmd_t;

  typedef struct packed {
    logic log_done;
    logic mul_done;
    logic div_done;
  } ntc_sts_t;
endpackage

/* rtl/ntc_beta_temperature_with_fault_core.sv */
// Top level of the thermistor beta-equation temperature block.
//
// Input channel: in_valid/in_stall with adc_sample and self_test; a beat is
// taken when in_valid is high and in_stall low. Output channel: out_valid/
// out_stall with temp_centi and status, held in an output register.
// A fault or self-test beat gives its result in the cycle after acceptance.
// A converted sample passes through two 24-step log2 runs on the shared
// squaring unit, ln2 scaling and the denominator, a 58-step restoring
// divider and then the output register. One item is in flight at a time,
// so a new sample is taken only after the previous conversion has been
// handed to the output register.
// The next beat may be accepted in the cycle in which the previous result
// is taken. If the receiver stalls, the result holds, the input stalls, and
// a finished conversion waits until the output register is free.
// Synchronous reset clears the fault counter and the handshake state and
// loads fault_low 100, fault_high 4000.
// Registers over APB: fault_low at 0x0, fault_high at 0x4.
`timescale 1ns / 1ps
module ntc_beta_temperature_with_fault_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        adc_sample,
  input  logic               self_test,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] temp_centi,
  output logic [1:0]         status
);
  logic [11:0] fault_low;
  logic [11:0] fault_high;
  ntc_pkg::ntc_cmd_t cmd;
  ntc_pkg::ntc_sts_t sts;
  logic signed [16:0] temp_conv;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_low <= 12'd100;
      fault_high <= 12'd4000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ntc_pkg::RegFaultLow:  fault_low <= pwdata[11:0];
        ntc_pkg::RegFaultHigh: fault_high <= pwdata[11:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[2])
      ntc_pkg::RegFaultLow:  prdata = {20'd0, fault_low};
      ntc_pkg::RegFaultHigh: prdata = {20'd0, fault_high};
      default: prdata = 32'd0;
    endcase
  end

  ntc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .adc_sample, .self_test,
    .fault_low, .fault_high, .cmd, .sts, .temp_conv,
    .out_valid, .out_stall, .temp_centi, .status
  );
  ntc_datapath u_dp (
    .clk, .rst, .cmd, .adc_sample, .sts, .temp_conv
  );
endmodule

/* rtl/ntc_datapath.sv */
// Datapath: shared log2 unit, ln2 scaling multiplier and restoring divider.
`timescale 1ns / 1ps
module ntc_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  ntc_pkg::ntc_cmd_t        cmd,
  input  logic [11:0]              adc_sample,
  output ntc_pkg::ntc_sts_t        sts,
  output logic signed [16:0]       temp_conv
);
  logic [11:0] adc;
  logic [12:0] opnd;
  logic [4:0]  lcnt;
  logic [30:0] m;
  logic [27:0] acc;
  logic [27:0] log_a;
  logic        log_busy;
  logic        log_done;
  logic [61:0] sq;
  logic [3:0]  kf;
  logic [27:0] mag;
  logic        neg;
  logic [1:0]  mph;
  logic        mul_done;
  logic [57:0] prod;
  logic signed [47:0] den;
  logic [57:0] rem;
  logic [57:0] quo;
  logic [5:0]  dcnt;
  logic        div_busy;
  logic        div_done;
  logic [58:0] trial;
  logic [57:0] qr;
  logic signed [58:0] t;
  logic [28:0] dd;

  // The first log starts in the accepting cycle, before the sample register is loaded.
  assign opnd = cmd.log_sel ? (13'h1000 - {1'b0, adc})
                            : {1'b0, (cmd.load ? adc_sample : adc)};
  always_comb begin
    kf = 4'd0;
    for (int i = 1; i < 13; i++) begin
      if (opnd[i]) kf = 4'(i);
    end
  end
  assign sq = 62'(m) * 62'(m);
  assign dd = {1'b0, log_a} - {1'b0, acc};
  assign trial = {rem, quo[57]} - {11'd0, den};
  assign sts = {log_done, mul_done, div_done};

  always_ff @(posedge clk) begin
    if (cmd.load) adc <= adc_sample;
    if (cmd.log_save) log_a <= acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_busy <= 1'b0;
      log_done <= 1'b0;
    end else if (cmd.log_start) begin
      m <= 31'((43'(opnd) << ntc_pkg::MantBits) >> kf);
      acc <= 28'(kf) << ntc_pkg::FracBits;
      lcnt <= 5'(ntc_pkg::FracBits - 1);
      log_busy <= 1'b1;
      log_done <= 1'b0;
    end else if (log_busy) begin
      if (sq[61:30] >= 32'h8000_0000) begin
        m <= 31'(sq >> (ntc_pkg::MantBits + 1));
        acc[lcnt] <= 1'b1;
      end else begin
        m <= 31'(sq >> ntc_pkg::MantBits);
      end
      log_busy <= (lcnt != 5'd0);
      log_done <= (lcnt == 5'd0);
      lcnt <= lcnt - 5'd1;
    end else begin
      log_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mph <= 2'd0;
      mul_done <= 1'b0;
    end else if (cmd.mul_start) begin
      neg <= dd[28];
      mag <= dd[28] ? 28'(-dd) : dd[27:0];
      mph <= 2'd1;
      mul_done <= 1'b0;
    end else if (mph == 2'd1) begin
      prod <= 58'(mag) * 58'(ntc_pkg::Ln2Q30);
      mph <= 2'd2;
      mul_done <= 1'b0;
    end else if (mph == 2'd2) begin
      den <= neg ? ntc_pkg::DenBase - 48'(prod[57:30]) * 48'sd29815
                 : ntc_pkg::DenBase + 48'(prod[57:30]) * 48'sd29815;
      mph <= 2'd0;
      mul_done <= 1'b1;
    end else begin
      mul_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else if (cmd.div_start) begin
      rem <= 58'd0;
      quo <= ntc_pkg::NumConst + 58'(den >>> 1);
      dcnt <= 6'd57;
      div_busy <= 1'b1;
      div_done <= 1'b0;
    end else if (div_busy) begin
      if (!trial[58]) rem <= trial[57:0];
      else rem <= {rem[56:0], quo[57]};
      quo <= {quo[56:0], ~trial[58]};
      div_busy <= (dcnt != 6'd0);
      div_done <= (dcnt == 6'd0);
      dcnt <= dcnt - 6'd1;
    end else begin
      div_done <= 1'b0;
    end
  end

  assign qr = quo;
  always_comb begin
    t = $signed({1'b0, qr}) - 59'sd27315;
    if (adc == 12'd0 || den <= 0) temp_conv = (adc == 12'd0) ? ntc_pkg::TempLo : ntc_pkg::TempHi;
    else if (t > 59'(ntc_pkg::TempHi)) temp_conv = ntc_pkg::TempHi;
    else if (t < 59'(ntc_pkg::TempLo)) temp_conv = ntc_pkg::TempLo;
    else temp_conv = 17'(t);
  end
endmodule

/* rtl/ntc_ctrl.sv */
// Controller: sequences the log, multiply and divide steps and the fault logic.
`timescale 1ns / 1ps
module ntc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [11:0]          adc_sample,
  input  logic                 self_test,
  input  logic [11:0]          fault_low,
  input  logic [11:0]          fault_high,
  output ntc_pkg::ntc_cmd_t    cmd,
  input  ntc_pkg::ntc_sts_t    sts,
  input  logic signed [16:0]   temp_conv,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [16:0]   temp_centi,
  output logic [1:0]           status
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLogA = 3'd1;
  localparam logic [2:0] SLogB = 3'd2;
  localparam logic [2:0] SMul  = 3'd3;
  localparam logic [2:0] SDiv  = 3'd4;
  localparam logic [2:0] SOut  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] fault_run;
  logic [2:0] fault_run_next;
  logic       out_valid_next;
  logic signed [16:0] temp_centi_next;
  logic [1:0] status_next;
  logic       acc_in;
  logic       is_fault;

  assign in_stall = (state != SIdle) || (out_valid && out_stall);
  assign acc_in = in_valid && !in_stall;
  assign is_fault = (adc_sample <= fault_low) || (adc_sample >= fault_high);

  always_comb begin
    cmd = '0;
    cmd.load = acc_in;
    cmd.log_start = acc_in || (state == SLogA && sts.log_done);
    cmd.log_sel = (state == SLogA);
    cmd.log_save = (state == SLogA && sts.log_done);
    cmd.mul_start = (state == SLogB && sts.log_done);
    cmd.div_start = (state == SMul && sts.mul_done);
  end

  always_comb begin
    state_next = state;
    fault_run_next = fault_run;
    out_valid_next = out_valid && out_stall;
    temp_centi_next = temp_centi;
    status_next = status;
    unique case (state)
      SIdle: begin
        if (acc_in) begin
          if (is_fault) begin
            if (fault_run < ntc_pkg::RunMax) fault_run_next = fault_run + 3'd1;
          end else begin
            fault_run_next = 3'd0;
          end
          if (is_fault && fault_run > 3'(ntc_pkg::FaultLimit)) begin
            temp_centi_next = ntc_pkg::Sentinel;
            status_next = ntc_pkg::StFault;
            out_valid_next = 1'b1;
          end else if (self_test) begin
            temp_centi_next = ntc_pkg::Sentinel;
            status_next = ntc_pkg::StTest;
            out_valid_next = 1'b1;
          end else begin
            state_next = SLogA;
          end
        end
      end
      SLogA: if (sts.log_done) state_next = SLogB;
      SLogB: if (sts.log_done) state_next = SMul;
      SMul:  if (sts.mul_done) state_next = SDiv;
      SDiv:  if (sts.div_done) state_next = SOut;
      SOut: begin
        if (!out_valid || !out_stall) begin
          temp_centi_next = temp_conv;
          status_next = ntc_pkg::StNormal;
          out_valid_next = 1'b1;
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      fault_run <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fault_run <= fault_run_next;
      out_valid <= out_valid_next;
    end
    temp_centi <= temp_centi_next;
    status <= status_next;
  end
endmodule

/* rtl/ntc_checker.sv */
// Port-level checker for the thermistor block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [16:0] temp_centi,
  input logic [1:0]         status
);
  `CHK_IMPL(a_status_code, clk, rst, out_valid, status == ntc_pkg::StNormal || status == ntc_pkg::StFault || status == ntc_pkg::StTest)
  `CHK_IMPL(a_sentinel, clk, rst, out_valid && status != ntc_pkg::StNormal, temp_centi == ntc_pkg::Sentinel)
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(temp_centi))
  `CHK_IMPL(a_range, clk, rst, out_valid, temp_centi >= ntc_pkg::TempLo && temp_centi <= ntc_pkg::TempHi)
endmodule

bind ntc_beta_temperature_with_fault_core ntc_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .temp_centi, .status
);
